/* hw/rtl/ts_section_reassembler_crc_defines.svh */
// Assertion macros shared by the section reassembler RTL.
// Depends on: nothing; users must have aclk and aresetn in scope.
`ifndef TS_SECTION_REASSEMBLER_CRC_DEFINES_SVH
`define TS_SECTION_REASSEMBLER_CRC_DEFINES_SVH

`ifndef SYNTH
`define TSSR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("tssr assertion failed");
`define TSSR_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("tssr assertion failed");
`else
`define TSSR_ASSERT(lbl, prop)
`define TSSR_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

/* hw/rtl/tssr_pkg.sv */
// Types, constants and widths for the transport-stream section reassembler.
// Depends on: nothing.
package tssr_pkg;

    localparam int PID_W  = 13;
    localparam int CC_W   = 4;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 13;
    localparam int CRC_W  = 32;
    localparam int NIB_W  = 4;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 5;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [LEN_W-1:0] HEAD_BYTES = 13'd3;
    localparam logic [LEN_W-1:0] LEN_HI_POS = 13'd1;
    localparam logic [LEN_W-1:0] LEN_LO_POS = 13'd2;

    typedef enum logic [1:0] {
        CHUNK_OK           = 2'd0,
        CHUNK_PID_MISMATCH = 2'd1,
        CHUNK_CC_MISMATCH  = 2'd2
    } chunk_status_t;

    typedef struct packed {
        logic              mode;
        logic              first_of_chunk;
        logic [PID_W-1:0]  pid;
        logic [CC_W-1:0]   continuity;
        logic [BYTE_W-1:0] data_byte;
    } in_beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic              byte_kept;
        chunk_status_t     chunk_status;
        logic              section_complete;
        logic              crc_ok;
        logic [LEN_W-1:0]  present_length;
    } result_t;

endpackage

/* hw/rtl/tssr_crc_byte.sv */
// Byte-parallel CRC-32/MPEG-2 update, MSB first, no reflection.
// Depends on: tssr_pkg.
module tssr_crc_byte (
    input  logic [tssr_pkg::CRC_W-1:0]  crc_in,
    input  logic [tssr_pkg::BYTE_W-1:0] data_in,
    output logic [tssr_pkg::CRC_W-1:0]  crc_out
);
    import tssr_pkg::*;

    logic [CRC_W-1:0] crc_v;

    always_comb begin
        crc_v = crc_in ^ {data_in, {(CRC_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++) begin
            if (crc_v[CRC_W-1]) begin
                crc_v = {crc_v[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc_v = {crc_v[CRC_W-2:0], 1'b0};
            end
        end
        crc_out = crc_v;
    end

endmodule

/* hw/rtl/tssr_section_ctl.sv */
// Section state: chunk checks, length capture, byte count and running CRC.
// Depends on: tssr_pkg, tssr_crc_byte, ts_section_reassembler_crc_defines.svh.
module tssr_section_ctl (
    input  logic               aclk,
    input  logic               aresetn,
    input  tssr_pkg::in_beat_t beat,
    input  logic               fire,
    output tssr_pkg::result_t  result
);
    import tssr_pkg::*;
    `include "ts_section_reassembler_crc_defines.svh"

    logic [PID_W-1:0]  held_pid_reg,           held_pid_next;
    logic [CC_W-1:0]   held_counter_reg,       held_counter_next;
    logic [LEN_W-1:0]  section_total_reg,      section_total_next;
    logic [LEN_W-1:0]  received_count_reg,     received_count_next;
    logic [CRC_W-1:0]  running_crc_reg,        running_crc_next;
    logic [NIB_W-1:0]  length_high_nibble_reg, length_high_nibble_next;
    logic              section_open_reg,       section_open_next;
    chunk_status_t     chunk_verdict_reg,      chunk_verdict_next;

    logic              start;
    logic              room;
    logic              kept;
    logic              complete;
    logic [CRC_W-1:0]  crc_base;
    logic [CRC_W-1:0]  crc_upd;

    assign start    = beat.first_of_chunk && beat.mode;
    assign crc_base = start ? CRC_INIT : running_crc_reg;

    tssr_crc_byte u_crc (
        .crc_in  (crc_base),
        .data_in (beat.data_byte),
        .crc_out (crc_upd)
    );

    always_comb begin
        held_pid_next           = held_pid_reg;
        held_counter_next       = held_counter_reg;
        section_total_next      = section_total_reg;
        received_count_next     = received_count_reg;
        running_crc_next        = crc_base;
        length_high_nibble_next = length_high_nibble_reg;
        section_open_next       = section_open_reg;
        chunk_verdict_next      = chunk_verdict_reg;

        if (beat.first_of_chunk) begin
            if (beat.mode) begin
                held_pid_next           = beat.pid;
                held_counter_next       = beat.continuity;
                section_total_next      = '0;
                received_count_next     = '0;
                length_high_nibble_next = '0;
                section_open_next       = 1'b1;
                chunk_verdict_next      = CHUNK_OK;
            end else if (!section_open_reg || beat.pid != held_pid_reg) begin
                chunk_verdict_next = CHUNK_PID_MISMATCH;
            end else if (beat.continuity != CC_W'(held_counter_reg + 1'b1)) begin
                chunk_verdict_next = CHUNK_CC_MISMATCH;
            end else begin
                held_counter_next  = beat.continuity;
                chunk_verdict_next = CHUNK_OK;
            end
        end

        room = (section_total_next == '0) ? (received_count_next < HEAD_BYTES)
                                          : (received_count_next < section_total_next);
        kept = section_open_next && (chunk_verdict_next == CHUNK_OK) && room;

        if (kept) begin
            running_crc_next = crc_upd;
            if (received_count_next == LEN_HI_POS) begin
                length_high_nibble_next = beat.data_byte[NIB_W-1:0];
            end else if (received_count_next == LEN_LO_POS) begin
                section_total_next = HEAD_BYTES
                                   + {1'b0, length_high_nibble_next, beat.data_byte};
            end
            received_count_next = received_count_next + 1'b1;
        end

        complete = (section_total_next != '0)
                && (received_count_next == section_total_next);

        result.byte_out         = beat.data_byte;
        result.byte_kept        = kept;
        result.chunk_status     = chunk_verdict_next;
        result.section_complete = complete;
        result.crc_ok           = complete && (running_crc_next == '0);
        result.present_length   = received_count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_pid_reg           <= '0;
            held_counter_reg       <= '0;
            section_total_reg      <= '0;
            received_count_reg     <= '0;
            running_crc_reg        <= CRC_INIT;
            length_high_nibble_reg <= '0;
            section_open_reg       <= 1'b0;
            chunk_verdict_reg      <= CHUNK_OK;
        end else if (fire) begin
            held_pid_reg           <= held_pid_next;
            held_counter_reg       <= held_counter_next;
            section_total_reg      <= section_total_next;
            received_count_reg     <= received_count_next;
            running_crc_reg        <= running_crc_next;
            length_high_nibble_reg <= length_high_nibble_next;
            section_open_reg       <= section_open_next;
            chunk_verdict_reg      <= chunk_verdict_next;
        end
    end

    `TSSR_ASSERT(a_count_within_total, (section_total_reg != '0) |-> (received_count_reg <= section_total_reg))
    `TSSR_ASSERT(a_total_after_header, (section_total_reg != '0) |-> (received_count_reg >= HEAD_BYTES))
    `TSSR_ASSERT(a_closed_is_empty, !section_open_reg |-> (received_count_reg == '0 && section_total_reg == '0))
    `TSSR_ASSERT_NEXT(a_idle_holds_count, !fire, $stable(received_count_reg) && $stable(running_crc_reg))

endmodule

/* hw/rtl/ts_section_reassembler_crc.sv */
// Top level of the transport-stream section reassembler with CRC-32/MPEG-2 check.
// Depends on: tssr_pkg, tssr_section_ctl, ts_section_reassembler_crc_defines.svh.
//
//   channel  dir  tdata (low bit up)                       tuser (low bit up)
//   s_       in   pid, continuity, data_byte               mode, first_of_chunk
//   m_       out  byte_out, present_length                 byte_kept, chunk_status,
//                                                          section_complete, crc_ok
//
// One beat per cycle unless m_ stalls; beats pass input then output register.
// The byte-wide CRC update and the section state update sit in one cycle.
// Reset is synchronous on aresetn and clears both stage valids and the section state.
// With m_tready low the result holds, one more beat is taken into the input
// register, then s_tready drops until the result leaves.
module ts_section_reassembler_crc (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // pid [12:0], continuity [16:13], data_byte [24:17], zero fill
    input  logic [tssr_pkg::S_TDATA_W-1:0] s_tdata,
    // mode [0], first_of_chunk [1]
    input  logic [tssr_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // byte_out [7:0], present_length [20:8], zero fill
    output logic [tssr_pkg::M_TDATA_W-1:0] m_tdata,
    // byte_kept [0], chunk_status [2:1], section_complete [3], crc_ok [4]
    output logic [tssr_pkg::M_TUSER_W-1:0] m_tuser
);
    import tssr_pkg::*;
    `include "ts_section_reassembler_crc_defines.svh"

    logic     in_valid_reg,  in_valid_next;
    in_beat_t in_beat_reg;
    logic     out_valid_reg, out_valid_next;
    result_t  out_result_reg;

    in_beat_t s_beat;
    result_t  result;
    logic     advance;
    logic     s_take;

    assign s_beat.mode           = s_tuser[0];
    assign s_beat.first_of_chunk = s_tuser[1];
    assign s_beat.pid            = s_tdata[PID_W-1:0];
    assign s_beat.continuity     = s_tdata[PID_W+CC_W-1:PID_W];
    assign s_beat.data_byte      = s_tdata[PID_W+CC_W+BYTE_W-1:PID_W+CC_W];

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = s_tready ? s_tvalid : in_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    tssr_section_ctl u_ctl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .beat    (in_beat_reg),
        .fire    (advance),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_beat_reg <= s_beat;
        end
        if (advance) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-LEN_W-BYTE_W){1'b0}},
                       out_result_reg.present_length, out_result_reg.byte_out};
    assign m_tuser  = {out_result_reg.crc_ok, out_result_reg.section_complete,
                       out_result_reg.chunk_status, out_result_reg.byte_kept};

    `TSSR_ASSERT(a_kept_means_ok, (out_valid_reg && out_result_reg.byte_kept) |-> (out_result_reg.chunk_status == CHUNK_OK))
    `TSSR_ASSERT(a_crc_ok_needs_complete, (out_valid_reg && out_result_reg.crc_ok) |-> out_result_reg.section_complete)
    `TSSR_ASSERT(a_full_stall_blocks_input, (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)

endmodule

/* test/tb_top.sv */
// Testbench for ts_section_reassembler_crc: a directed table, then randomized sections
// (good and bad CRC, rejected chunks, overrun, truncation, noise), all checked beat by beat.
// Depends on: tssr_pkg and the reassembler RTL.
`timescale 1ns / 100ps

module tb_top;
    import tssr_pkg::*;

    localparam int DIR_ROWS   = 25;
    localparam int RAND_BEATS = 700;
    localparam int DRAIN      = 16;
    localparam int LIMIT      = 200000;

    typedef struct packed {
        logic        mode;
        logic        first;
        logic [12:0] pid;
        logic [3:0]  cc;
        logic [7:0]  data;
        logic [2:0]  tail;
        logic        typed;
        result_t     want;
    } stim_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    stim_t   beat_plan [$];
    result_t want_q [$];
    stim_t   cur;
    stim_t   nxt;
    result_t seen;
    result_t exp_r;
    result_t pred_r;
    logic [31:0] crc_snap;
    int burst_left = 0;
    int gap_left = 0;
    int rx_ctr = 0;
    int rx_style = 0;
    int cycles = 0;
    int beats_taken = 0;
    int results_seen = 0;
    int good_sections = 0;
    int errors = 0;

    // section state of the predictor
    logic [12:0]   held_pid;
    logic [3:0]    held_cc;
    logic [12:0]   sec_total;
    logic [12:0]   sec_count;
    logic [31:0]   sec_crc;
    logic [3:0]    len_hi;
    logic          sec_open;
    chunk_status_t verdict;

    logic [12:0] pid_pool [4] = '{13'h0000, 13'h0011, 13'h1FFF, 13'h0A5A};

    stim_t dir_tab [DIR_ROWS] = '{
        '{1'b0, 1'b0, 13'h0000, 4'h0, 8'hA5, 3'd0, 1'b1,
          '{8'hA5, 1'b0, CHUNK_OK, 1'b0, 1'b0, 13'd0}},
        '{1'b0, 1'b1, 13'h1FFF, 4'hF, 8'hFF, 3'd0, 1'b1,
          '{8'hFF, 1'b0, CHUNK_PID_MISMATCH, 1'b0, 1'b0, 13'd0}},
        '{1'b0, 1'b0, 13'h0000, 4'h0, 8'h00, 3'd0, 1'b1,
          '{8'h00, 1'b0, CHUNK_PID_MISMATCH, 1'b0, 1'b0, 13'd0}},
        '{1'b1, 1'b1, 13'h0000, 4'h0, 8'h00, 3'd0, 1'b0, '0},
        '{1'b0, 1'b0, 13'h0000, 4'h0, 8'hB0, 3'd0, 1'b0, '0},
        '{1'b0, 1'b0, 13'h0000, 4'h0, 8'h05, 3'd0, 1'b0, '0},
        '{1'b0, 1'b1, 13'h0000, 4'h1, 8'h7E, 3'd0, 1'b0, '0},
        '{1'b0, 1'b1, 13'h0001, 4'h2, 8'hC3, 3'd0, 1'b1,
          '{8'hC3, 1'b0, CHUNK_PID_MISMATCH, 1'b0, 1'b0, 13'd4}},
        '{1'b0, 1'b1, 13'h0000, 4'h3, 8'h3C, 3'd0, 1'b1,
          '{8'h3C, 1'b0, CHUNK_CC_MISMATCH, 1'b0, 1'b0, 13'd4}},
        '{1'b0, 1'b1, 13'h0000, 4'h2, 8'h00, 3'd1, 1'b0, '0},
        '{1'b0, 1'b0, 13'h0000, 4'h0, 8'h00, 3'd2, 1'b0, '0},
        '{1'b0, 1'b0, 13'h0000, 4'h0, 8'h00, 3'd3, 1'b0, '0},
        '{1'b0, 1'b0, 13'h0000, 4'h0, 8'h00, 3'd4, 1'b0, '0},
        '{1'b0, 1'b0, 13'h0000, 4'h0, 8'hE7, 3'd0, 1'b0, '0},
        '{1'b1, 1'b1, 13'h1FFF, 4'hF, 8'hFF, 3'd0, 1'b0, '0},
        '{1'b0, 1'b1, 13'h1FFF, 4'h0, 8'hFF, 3'd0, 1'b0, '0},
        '{1'b0, 1'b0, 13'h0000, 4'h0, 8'hFF, 3'd0, 1'b0, '0},
        '{1'b1, 1'b0, 13'h0000, 4'h0, 8'h12, 3'd0, 1'b0, '0},
        '{1'b1, 1'b1, 13'h0AAA, 4'h5, 8'h42, 3'd0, 1'b0, '0},
        '{1'b0, 1'b0, 13'h0000, 4'h0, 8'hF0, 3'd0, 1'b0, '0},
        '{1'b0, 1'b0, 13'h0000, 4'h0, 8'h00, 3'd0, 1'b0, '0},
        '{1'b0, 1'b0, 13'h0000, 4'h0, 8'h55, 3'd0, 1'b0, '0},
        '{1'b0, 1'b1, 13'h0AAA, 4'h6, 8'h33, 3'd0, 1'b0, '0},
        '{1'b0, 1'b1, 13'h0AAA, 4'h6, 8'h80, 3'd0, 1'b0, '0},
        '{1'b1, 1'b1, 13'h1555, 4'hA, 8'h01, 3'd0, 1'b0, '0}
    };

    ts_section_reassembler_crc dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic result_t reassemble_beat(stim_t b);
        result_t r;
        logic    room;
        int      k;
        if (b.first) begin
            if (b.mode) begin
                held_pid  = b.pid;
                held_cc   = b.cc;
                sec_total = '0;
                sec_count = '0;
                sec_crc   = CRC_INIT;
                len_hi    = '0;
                sec_open  = 1'b1;
                verdict   = CHUNK_OK;
            end else if (!sec_open || b.pid != held_pid) begin
                verdict = CHUNK_PID_MISMATCH;
            end else if (b.cc != held_cc + 4'd1) begin
                verdict = CHUNK_CC_MISMATCH;
            end else begin
                held_cc = b.cc;
                verdict = CHUNK_OK;
            end
        end
        r = '0;
        r.byte_out = b.data;
        r.chunk_status = verdict;
        if (sec_open && verdict == CHUNK_OK) begin
            room = (sec_total == 0) ? (sec_count < HEAD_BYTES) : (sec_count < sec_total);
            if (room) begin
                r.byte_kept = 1'b1;
                sec_crc ^= {b.data, 24'h0};
                for (k = 0; k < 8; k++)
                    sec_crc = sec_crc[31] ? ((sec_crc << 1) ^ CRC_POLY) : (sec_crc << 1);
                if (sec_count == LEN_HI_POS)
                    len_hi = b.data[3:0];
                else if (sec_count == LEN_LO_POS)
                    sec_total = HEAD_BYTES + {len_hi, b.data};
                sec_count = sec_count + 13'd1;
            end
        end
        r.section_complete = (sec_total != 0) && (sec_count == sec_total);
        r.crc_ok = r.section_complete && (sec_crc == 0);
        r.present_length = sec_count;
        return r;
    endfunction

    // one section split into chunks, with rejected chunks, overrun or truncation mixed in
    task automatic plan_section();
        logic [12:0] pid;
        logic [3:0]  cc;
        logic [11:0] slen;
        logic [7:0]  body [$];
        logic [2:0]  tails [$];
        stim_t       st;
        int          total;
        int          n;
        int          pos;
        int          chunk;
        int          k;
        bit          good_crc;
        bit          first_chunk;
        pid = ($urandom_range(0, 3) != 0) ? pid_pool[$urandom_range(0, 3)]
                                          : 13'($urandom_range(0, 8191));
        cc = 4'($urandom_range(0, 15));
        slen = ($urandom_range(0, 11) == 0) ? 12'($urandom_range(41, 250))
                                            : 12'($urandom_range(0, 40));
        total = 3 + slen;
        good_crc = (slen >= 4) && ($urandom_range(0, 4) != 0);
        for (k = 0; k < total + 6; k++) begin
            body.push_back(8'($urandom_range(0, 255)));
            tails.push_back((good_crc && k >= total - 4 && k < total) ? 3'(k - total + 5) : 3'd0);
        end
        body[1] = {4'($urandom_range(0, 15)), slen[11:8]};
        body[2] = slen[7:0];
        n = total;
        if ($urandom_range(0, 9) == 0)
            n = $urandom_range(1, total - 1);
        else if ($urandom_range(0, 4) == 0)
            n = total + $urandom_range(1, 6);
        pos = 0;
        first_chunk = 1'b1;
        while (pos < n) begin
            if (!first_chunk && $urandom_range(0, 6) == 0) begin
                chunk = $urandom_range(1, 4);
                for (k = 0; k < chunk; k++) begin
                    st = '0;
                    st.first = (k == 0);
                    st.mode = (k == 0) ? 1'b0 : 1'($urandom_range(0, 1));
                    st.data = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 1) == 0) begin
                        st.pid = pid ^ 13'($urandom_range(1, 8191));
                        st.cc = cc + 4'd1;
                    end else begin
                        st.pid = pid;
                        st.cc = cc + 4'd1 + 4'($urandom_range(1, 14));
                    end
                    beat_plan.push_back(st);
                end
            end
            if (!first_chunk)
                cc = cc + 4'd1;
            chunk = first_chunk ? $urandom_range(1, 14) : $urandom_range(1, 12);
            for (k = 0; k < chunk && pos < n; k++) begin
                st = '0;
                st.first = (k == 0);
                st.mode = (k == 0) ? first_chunk : 1'($urandom_range(0, 1));
                st.pid = (k == 0) ? pid : 13'($urandom_range(0, 8191));
                st.cc = (k == 0) ? cc : 4'($urandom_range(0, 15));
                st.data = body[pos];
                st.tail = tails[pos];
                beat_plan.push_back(st);
                pos++;
            end
            first_chunk = 1'b0;
        end
    endtask

    task automatic flag_error(string why, result_t w, result_t g);
        errors++;
        if (errors <= 10)
            $display("%s: want byte=%02h kept=%0d st=%0d cmpl=%0d crc=%0d len=%0d | got byte=%02h kept=%0d st=%0d cmpl=%0d crc=%0d len=%0d",
                     why, w.byte_out, w.byte_kept, w.chunk_status, w.section_complete,
                     w.crc_ok, w.present_length, g.byte_out, g.byte_kept, g.chunk_status,
                     g.section_complete, g.crc_ok, g.present_length);
    endtask

    // sender: bursts with random gaps; predicts each beat as it is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            held_pid  = '0;
            held_cc   = '0;
            sec_total = '0;
            sec_count = '0;
            sec_crc   = CRC_INIT;
            len_hi    = '0;
            sec_open  = 1'b0;
            verdict   = CHUNK_OK;
        end else begin
            if (s_tvalid && s_tready) begin
                pred_r = reassemble_beat(cur);
                want_q.push_back(cur.typed ? cur.want : pred_r);
                beats_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (beat_plan.size() > 0) begin
                    nxt = beat_plan.pop_front();
                    if (nxt.tail == 3'd1)
                        crc_snap = sec_crc;
                    if (nxt.tail != 3'd0)
                        nxt.data = crc_snap[8 * (4 - nxt.tail) +: 8];
                    cur = nxt;
                    s_tdata  <= {7'd0, nxt.data, nxt.cc, nxt.pid};
                    s_tuser  <= {nxt.first, nxt.mode};
                    s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall style is redrawn at random from four styles
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_ctr++;
            if (rx_ctr % 48 == 0)
                rx_style = $urandom_range(0, 3);
            case (rx_style)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 2) != 0);
                2: m_tready <= (rx_ctr % 16 < 10);
                default: m_tready <= rx_ctr[0];
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            seen.byte_out = m_tdata[7:0];
            seen.present_length = m_tdata[20:8];
            seen.byte_kept = m_tuser[0];
            seen.chunk_status = chunk_status_t'(m_tuser[2:1]);
            seen.section_complete = m_tuser[3];
            seen.crc_ok = m_tuser[4];
            if (seen.byte_kept && seen.crc_ok)
                good_sections++;
            if (want_q.size() == 0) begin
                flag_error("unexpected beat", '0, seen);
            end else begin
                exp_r = want_q.pop_front();
                if (seen.byte_out !== exp_r.byte_out || seen.byte_kept !== exp_r.byte_kept
                    || seen.chunk_status !== exp_r.chunk_status
                    || seen.section_complete !== exp_r.section_complete
                    || seen.crc_ok !== exp_r.crc_ok
                    || seen.present_length !== exp_r.present_length)
                    flag_error("mismatch", exp_r, seen);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d beats taken", cycles, beats_taken);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        stim_t st;
        int    n;
        foreach (dir_tab[i])
            beat_plan.push_back(dir_tab[i]);
        while (beat_plan.size() < DIR_ROWS + RAND_BEATS) begin
            if ($urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    st = '0;
                    st.mode = 1'($urandom_range(0, 1));
                    st.first = ($urandom_range(0, 3) == 0);
                    st.pid = 13'($urandom_range(0, 8191));
                    st.cc = 4'($urandom_range(0, 15));
                    st.data = 8'($urandom_range(0, 255));
                    beat_plan.push_back(st);
                end
            end else begin
                plan_section();
            end
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (!(beat_plan.size() == 0 && !s_tvalid && want_q.size() == 0))
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        $display("%0d beats sent (%0d from the directed table), %0d results checked",
                 beats_taken, DIR_ROWS, results_seen);
        $display("%0d sections closed with a good CRC, %0d mismatches", good_sections, errors);
        if (errors == 0 && want_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
